[sv/cfcm_pkg.sv]
// Package for the charge false-color map: default widths, ramp segment bounds
// and the stage record that passes from the ramp stage to the level lookup.
// Depends on nothing; every other file of the block uses it.
package cfcm_pkg;

   localparam int CHARGE_BITS_DEFAULT = 12;
   localparam int COLOR_BITS_DEFAULT  = 8;

   // The ramp itself works on a 12-bit charge, saturated at its top value.
   localparam int RAMP_BITS = 12;
   localparam logic [RAMP_BITS-1:0] CHARGE_MAX = 12'd4095;

   // Segment boundaries of the ramp, in ADC counts.
   localparam logic [RAMP_BITS-1:0] SEG_GRAY_END  = 12'd60;
   localparam logic [RAMP_BITS-1:0] SEG_LOW_END   = 12'd120;
   localparam logic [RAMP_BITS-1:0] SEG_BLUE_END  = 12'd600;
   localparam logic [RAMP_BITS-1:0] SEG_BG_END    = 12'd800;
   localparam logic [RAMP_BITS-1:0] SEG_GREEN_END = 12'd1200;
   localparam logic [RAMP_BITS-1:0] SEG_GR_END    = 12'd1400;

   // Above the low segments each channel is k/200 of full scale.
   localparam int STEP_BITS   = 8;
   localparam int STEP_FULL   = 200;
   localparam int STEP_ENTRIES = STEP_FULL + 1;

   // Below the blue segment the color depends on the charge alone.
   localparam int LOW_BITS    = 7;
   localparam int LOW_ENTRIES = 120;
   localparam int GRAY_ENTRIES = 60;

   typedef struct packed {
      logic                 low;        // charge below the pure-blue segment
      logic [LOW_BITS-1:0]  low_idx;    // charge itself when low
      logic [STEP_BITS-1:0] step_red;   // channel steps when not low
      logic [STEP_BITS-1:0] step_green;
      logic [STEP_BITS-1:0] step_blue;
      logic                 highlight;
   } cfcm_ramp_type;

endpackage

[sv/cfcm_if.sv]
// Handshake channels of the charge false-color map: request (charge and
// highlight flag) and response (three color levels). Depends on cfcm_pkg.

interface cfcm_req_if #(
   parameter int CHARGE_BITS = cfcm_pkg::CHARGE_BITS_DEFAULT
) ();
   logic                   valid;
   logic                   ready;
   logic [CHARGE_BITS-1:0] charge;
   logic                   highlight;

   modport source (output valid, output charge, output highlight, input ready);
   modport sink   (input valid, input charge, input highlight, output ready);
endinterface

interface cfcm_rsp_if #(
   parameter int COLOR_BITS = cfcm_pkg::COLOR_BITS_DEFAULT
) ();
   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red_level;
   logic [COLOR_BITS-1:0] green_level;
   logic [COLOR_BITS-1:0] blue_level;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

[sv/charge_false_color_map_core.sv]
// Charge false-color map: a charge and a highlight flag in, one RGB color out.
// A result is offered on rsp once the request has passed the capture, ramp
// and level stages, later only while rsp is stalled.
// Throughput: one transfer per cycle while rsp is not stalled; the stages
// advance as a chain, so a free downstream slot lets every stage move in the same cycle.
// Reset: synchronous, active high; clears the stage valid bits only.
module charge_false_color_map_core #(
   parameter int CHARGE_BITS = cfcm_pkg::CHARGE_BITS_DEFAULT,
   parameter int COLOR_BITS  = cfcm_pkg::COLOR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cfcm_req_if.sink    req,
   cfcm_rsp_if.source  rsp
);
   import cfcm_pkg::*;

   // The pipeline has three register stages, each with its own valid bit.
   // Stage one captures the request. Stage two holds the ramp record: the
   // saturated charge sorted into its segment, with each channel given as a
   // step of 1/200 of full scale, or, below the pure-blue segment, the charge
   // itself. Stage three is the output register that drives rsp; its levels
   // come from constant tables computed exactly at elaboration, which also
   // carry the highlight brightening and the round-half-up scaling.

   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic                   v3_ff, v3_in;
   logic                   adv1, adv2, adv3;
   logic [CHARGE_BITS-1:0] charge_ff;
   logic                   highlight_ff;
   cfcm_ramp_type          ramp;

   // A stage may load when it is empty or when the stage after it moves on.
   assign adv3 = !v3_ff || rsp.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req.ready = adv1;
   assign rsp.valid = v3_ff;

   always_comb begin
      v1_in = adv1 ? req.valid : v1_ff;
      v2_in = adv2 ? v1_ff : v2_ff;
      v3_in = adv3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // The request payload is captured on every transfer.
   always_ff @(posedge clock) begin
      if (adv1) begin
         charge_ff    <= req.charge;
         highlight_ff <= req.highlight;
      end
   end

   cfcm_ramp #(
      .CHARGE_BITS (CHARGE_BITS)
   ) u_ramp (
      .clock     (clock),
      .load      (adv2),
      .charge    (charge_ff),
      .highlight (highlight_ff),
      .ramp      (ramp)
   );

   cfcm_level_lut #(
      .COLOR_BITS (COLOR_BITS)
   ) u_level (
      .clock       (clock),
      .load        (adv3),
      .ramp        (ramp),
      .red_level   (rsp.red_level),
      .green_level (rsp.green_level),
      .blue_level  (rsp.blue_level)
   );

   // Above the low segments the channel steps always add up to full scale.
   a_step_sum: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !ramp.low) |->
         ((10'(ramp.step_red) + 10'(ramp.step_green) + 10'(ramp.step_blue))
          == 10'(STEP_FULL)))
      else $error("ramp steps do not sum to full scale");

   // A stalled ramp record keeps its item and its contents.
   a_ramp_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !adv3) |=> (v2_ff && $stable(ramp)))
      else $error("ramp stage lost or changed an item while stalled");

   // An item that leaves the capture stage lands in the ramp stage.
   a_capture_move: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && adv2) |=> v2_ff)
      else $error("item dropped between capture and ramp stage");

   // The output stage never overwrites the red or blue level of a result that is still offered.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rsp.ready) |=> (v3_ff && $stable(rsp.red_level)
                                 && $stable(rsp.blue_level)))
      else $error("offered result overwritten");

endmodule

[sv/cfcm_ramp.sv]
// Ramp stage: saturates the charge, finds its segment and registers the
// per-channel steps into the stage record. Depends on cfcm_pkg.
module cfcm_ramp #(
   parameter int CHARGE_BITS = cfcm_pkg::CHARGE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic [CHARGE_BITS-1:0]   charge,
   input  logic                     highlight,
   output cfcm_pkg::cfcm_ramp_type  ramp
);
   import cfcm_pkg::*;

   // The saturation compare is done at the wider of the two widths, so no
   // charge bit is dropped before the test.
   localparam int SatBits = (CHARGE_BITS > RAMP_BITS) ? CHARGE_BITS : RAMP_BITS;

   logic [RAMP_BITS-1:0] charge_sat;
   logic                 over_max;
   cfcm_ramp_type        ramp_in;
   cfcm_ramp_type        ramp_ff;

   // With a narrow charge field the saturation test never fires.
   assign over_max   = SatBits'(charge) > SatBits'(CHARGE_MAX);
   assign charge_sat = over_max ? CHARGE_MAX : RAMP_BITS'(charge);

   always_comb begin
      ramp_in            = '0;
      ramp_in.highlight  = highlight;
      ramp_in.low_idx    = charge_sat[LOW_BITS-1:0];
      priority if (charge_sat < SEG_LOW_END) begin
         ramp_in.low = 1'b1;
      end else if (charge_sat < SEG_BLUE_END) begin
         ramp_in.step_blue = STEP_BITS'(STEP_FULL);
      end else if (charge_sat < SEG_BG_END) begin
         ramp_in.step_blue  = STEP_BITS'(SEG_BG_END - charge_sat);
         ramp_in.step_green = STEP_BITS'(charge_sat - SEG_BLUE_END);
      end else if (charge_sat < SEG_GREEN_END) begin
         ramp_in.step_green = STEP_BITS'(STEP_FULL);
      end else if (charge_sat < SEG_GR_END) begin
         ramp_in.step_green = STEP_BITS'(SEG_GR_END - charge_sat);
         ramp_in.step_red   = STEP_BITS'(charge_sat - SEG_GREEN_END);
      end else begin
         ramp_in.step_red = STEP_BITS'(STEP_FULL);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ramp_ff <= ramp_in;
      end
   end

   assign ramp = ramp_ff;

endmodule

[sv/cfcm_level_lut.sv]
// Level stage: turns the stage record into three rounded color levels
// through constant tables built at elaboration. Depends on cfcm_pkg.
module cfcm_level_lut #(
   parameter int COLOR_BITS = cfcm_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     load,
   input  cfcm_pkg::cfcm_ramp_type  ramp,
   output logic [COLOR_BITS-1:0]    red_level,
   output logic [COLOR_BITS-1:0]    green_level,
   output logic [COLOR_BITS-1:0]    blue_level
);
   import cfcm_pkg::*;

   localparam longint unsigned LevelMax = (64'd1 << COLOR_BITS) - 64'd1;

   // Step tables: plain and brightened level for a channel at k/200.
   logic [COLOR_BITS-1:0] step_plain_w [STEP_ENTRIES];
   logic [COLOR_BITS-1:0] step_bright_w [STEP_ENTRIES];
   // Low tables: red/green pair and blue, plain and brightened, by charge.
   logic [COLOR_BITS-1:0] low_rg_plain_w [LOW_ENTRIES];
   logic [COLOR_BITS-1:0] low_b_plain_w [LOW_ENTRIES];
   logic [COLOR_BITS-1:0] low_rg_bright_w [LOW_ENTRIES];
   logic [COLOR_BITS-1:0] low_b_bright_w [LOW_ENTRIES];

   logic [COLOR_BITS-1:0] red_in, green_in, blue_in;
   logic [COLOR_BITS-1:0] red_ff, green_ff, blue_ff;

   // Above the low segments the sum of the channels is always full scale,
   // so brightening gives 0.65 + 0.35 * x with x = k/200.
   for (genvar i = 0; i < STEP_ENTRIES; i++) begin : g_step
      localparam longint unsigned K      = i;
      localparam longint unsigned Plain  = (K * LevelMax + 100) / 200;
      localparam longint unsigned Bright = (LevelMax * (7 * K + 2600) + 2000) / 4000;
      assign step_plain_w[i]  = COLOR_BITS'(Plain);
      assign step_bright_w[i] = COLOR_BITS'(Bright);
   end

   // Channels in 1/600 units; Rem is 600 times the headroom.
   for (genvar i = 0; i < LOW_ENTRIES; i++) begin : g_low
      localparam longint unsigned C    = i;
      localparam bit              Gray = (i < GRAY_ENTRIES);
      localparam longint unsigned NRg  = Gray ? (120 + 3 * C) : (5 * (120 - C));
      localparam longint unsigned NB   = Gray ? (120 + 3 * C) : (5 * C);
      localparam longint unsigned Rem  = Gray ? (1440 - 9 * C) : (600 + 5 * C);
      localparam longint unsigned NumRg = 10 * NRg * Rem + 7800 * (600 - NRg);
      localparam longint unsigned NumB  = 10 * NB * Rem + 7800 * (600 - NB);
      localparam longint unsigned PlainRg  = (NRg * LevelMax + 300) / 600;
      localparam longint unsigned PlainB   = (NB * LevelMax + 300) / 600;
      localparam longint unsigned BrightRg =
         (NumRg * LevelMax + 3000 * Rem) / (6000 * Rem);
      localparam longint unsigned BrightB  =
         (NumB * LevelMax + 3000 * Rem) / (6000 * Rem);
      assign low_rg_plain_w[i]  = COLOR_BITS'(PlainRg);
      assign low_b_plain_w[i]   = COLOR_BITS'(PlainB);
      assign low_rg_bright_w[i] = COLOR_BITS'(BrightRg);
      assign low_b_bright_w[i]  = COLOR_BITS'(BrightB);
   end

   always_comb begin
      unique case ({ramp.low, ramp.highlight})
         2'b11: begin
            red_in   = low_rg_bright_w[ramp.low_idx];
            green_in = low_rg_bright_w[ramp.low_idx];
            blue_in  = low_b_bright_w[ramp.low_idx];
         end
         2'b10: begin
            red_in   = low_rg_plain_w[ramp.low_idx];
            green_in = low_rg_plain_w[ramp.low_idx];
            blue_in  = low_b_plain_w[ramp.low_idx];
         end
         2'b01: begin
            red_in   = step_bright_w[ramp.step_red];
            green_in = step_bright_w[ramp.step_green];
            blue_in  = step_bright_w[ramp.step_blue];
         end
         default: begin
            red_in   = step_plain_w[ramp.step_red];
            green_in = step_plain_w[ramp.step_green];
            blue_in  = step_plain_w[ramp.step_blue];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red_level   = red_ff;
   assign green_level = green_ff;
   assign blue_level  = blue_ff;

endmodule
